### src/spinning_mech_position_speed_model_unit_defines.svh
// Assertion macros shared by the spinning mechanism model RTL.
`ifndef SPINNING_MECH_POSITION_SPEED_MODEL_UNIT_DEFINES_SVH
`define SPINNING_MECH_POSITION_SPEED_MODEL_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define SPM_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("spm assertion failed");

// Next-cycle implication, checked outside reset.
`define SPM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("spm assertion failed");

`endif

### src/spm_pkg.sv
// Package with types, constants and codes for the spinning mechanism model.
package spm_pkg;

    // Ring of speed samples.
    localparam int SAMPLE_DEPTH = 8;
    localparam int IDX_W        = $clog2(SAMPLE_DEPTH);

    // Position geometry.
    localparam int POS_W     = 13;
    localparam int POS_MOD   = 5000;
    localparam int POS_MAX   = 4999;
    localparam int HALF_TURN = 2500;
    localparam int HOME_HIGH = 4900;
    localparam int HOME_LOW  = 100;

    // Drive register.
    localparam int LVL_W       = 3;
    localparam int SPEED_MAX   = 4;
    localparam int DIR_BIT_POS = 2;
    localparam int UP_BIT_POS  = 0;

    // Result widths.
    localparam int COARSE_W = 10;
    localparam int SPD_W    = 11;

    // Position / 5 by reciprocal multiplication.
    localparam int COARSE_MUL   = 52429;
    localparam int COARSE_MUL_W = 16;
    localparam int COARSE_SH    = 18;

    // Speed estimate: (sum / SAMPLE_DEPTH) / 3 equals |sum| / (3 * SAMPLE_DEPTH) with the
    // sign put back, done as one reciprocal multiplication.
    localparam int SPEED_DIV = 3;
    localparam int ENTRY_W   = POS_W;
    localparam int SUM_W     = $clog2(HALF_TURN * SAMPLE_DEPTH + 1) + 1;
    localparam int ABS_W     = SUM_W - 1;
    localparam int DIV_K     = SAMPLE_DEPTH * SPEED_DIV;
    localparam int DIV_SH    = $clog2(HALF_TURN * SAMPLE_DEPTH * DIV_K) + 1;
    localparam int DIV_RECIP = ((2 ** DIV_SH) + DIV_K - 1) / DIV_K;
    localparam int RECIP_W   = $clog2(DIV_RECIP + 1);

    // Opcodes and the one register offset that drives the mechanism.
    localparam logic [1:0] OPC_DRIVE    = 2'd0;
    localparam logic [1:0] OPC_SAMPLE   = 2'd1;
    localparam logic [1:0] DRIVE_OFFSET = 2'd3;

    typedef logic        [POS_W-1:0] t_pos;
    typedef logic        [LVL_W-1:0] t_lvl;
    typedef logic signed [1:0]       t_dir;
    typedef logic        [IDX_W-1:0] t_idx;
    typedef logic signed [ENTRY_W-1:0] t_entry;
    typedef logic signed [SUM_W-1:0]   t_sum;

    localparam t_dir DIR_STOP = 2'sb00;
    localparam t_dir DIR_FWD  = 2'sb01;
    localparam t_dir DIR_REV  = 2'sb11;

    // Access request to the sample ring.
    typedef struct packed {
        logic   rd_en;
        t_idx   rd_addr;
        logic   wr_en;
        t_idx   wr_addr;
        t_entry wr_data;
    } t_ring_req;

endpackage

### src/spm_if.sv
// Valid/ready channel interfaces for input items and result items.
interface spm_in_if
    import spm_pkg::*;
();
    logic       valid;
    logic       ready;
    logic [1:0] opcode;
    logic [1:0] reg_offset;
    logic [7:0] write_data;

    modport source (output valid, output opcode, output reg_offset, output write_data,
                    input ready);
    modport sink   (input valid, input opcode, input reg_offset, input write_data,
                    output ready);
endinterface

interface spm_out_if
    import spm_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic [COARSE_W-1:0]     coarse_position;
    logic                    home_switch;
    logic signed [SPD_W-1:0] speed_estimate;

    modport source (output valid, output coarse_position, output home_switch,
                    output speed_estimate, input ready);
    modport sink   (input valid, input coarse_position, input home_switch,
                    input speed_estimate, output ready);
endinterface

### src/spinning_mech_position_speed_model_unit.sv
// A result item passes through stage A, stage B and the output register once its item is accepted.
// Throughput: one item per cycle when no stage stalls; the ring memory is read when a sample item is accepted and
// written back one stage later, so consecutive samples never touch the same entry at once.
// Backpressure stalls each stage only when the stage after it is full.
// Reset (synchronous, active low) stops the mechanism, zeroes position, speed level, sum and
// index, and clears the ring valid bits so the ring reads as zero; no clearing pass is needed.
`include "spinning_mech_position_speed_model_unit_defines.svh"

module spinning_mech_position_speed_model_unit
    import spm_pkg::*;
(
    input  logic           i_clk,
    input  logic           i_rst_n,
    spm_in_if.sink         i_in,
    spm_out_if.source      o_out
);

    // Mechanism state, updated in the cycle an item is accepted; the running sum is updated from stage A.
    t_pos r_position, n_position;
    t_lvl r_level, n_level;
    t_dir r_dir, n_dir;
    t_pos r_last_pos;
    t_idx r_idx, n_idx_inc;
    t_sum r_sum, n_sum;

    // Pipeline stage A: ring read data arrives here.
    logic   r_a_valid;
    t_pos   r_a_pos;
    logic   r_a_sample;
    t_entry r_a_entry;
    t_idx   r_a_idx;

    // Pipeline stage B: divider input.
    logic                r_b_valid;
    logic [COARSE_W-1:0] r_b_coarse;
    logic                r_b_home;
    logic                r_b_sample;
    t_sum                r_b_sum;

    // Output register.
    logic                    r_o_valid;
    logic [COARSE_W-1:0]     r_o_coarse;
    logic                    r_o_home;
    logic signed [SPD_W-1:0] r_o_speed;

    logic accept, o_free, b_free, a_free, a_go;
    logic is_drive, is_sample;

    t_ring_req ring_req;
    t_entry    ring_old;

    // Stage-0 datapath.
    logic [POS_W:0] w_up_sum, w_dn_diff;
    logic signed [POS_W:0] w_delta, w_delta_neg;
    t_pos   w_dist_abs, w_dist;
    t_entry w_entry;

    // Stage-A datapath.
    logic [POS_W+COARSE_MUL_W-1:0] w_cprod;
    logic [COARSE_W-1:0]           w_coarse;
    logic                          w_home;

    // Stage-B datapath.
    logic [SUM_W-1:0]         w_mag_full;
    logic [ABS_W-1:0]         w_mag;
    logic [ABS_W+RECIP_W-1:0] w_qprod;
    logic [SPD_W-1:0]         w_quo;
    logic signed [SPD_W-1:0]  w_est;

    // Handshake: each stage takes a new item when it is empty or drains this cycle.
    always_comb begin
        o_free = !r_o_valid || o_out.ready;
        b_free = !r_b_valid || o_free;
        a_free = !r_a_valid || b_free;
        a_go   = r_a_valid && b_free;
    end

    assign i_in.ready = a_free;
    assign accept     = i_in.valid && a_free;
    assign is_drive   = (i_in.opcode == OPC_DRIVE) && (i_in.reg_offset == DRIVE_OFFSET);
    assign is_sample  = (i_in.opcode == OPC_SAMPLE);

    // Drive write: new direction and speed level, then the position steps by their product.
    always_comb begin
        n_dir = i_in.write_data[DIR_BIT_POS] ? DIR_FWD : DIR_REV;
        n_level = r_level;
        if (i_in.write_data[UP_BIT_POS]) begin
            if (r_level < LVL_W'(SPEED_MAX)) begin
                n_level = r_level + LVL_W'(1);
            end
        end else begin
            if (r_level != '0) begin
                n_level = r_level - LVL_W'(1);
            end
        end

        w_up_sum  = {1'b0, r_position} + {{(POS_W + 1 - LVL_W){1'b0}}, n_level};
        w_dn_diff = {1'b0, r_position} - {{(POS_W + 1 - LVL_W){1'b0}}, n_level};
        if (n_dir == DIR_FWD) begin
            if (w_up_sum > (POS_W + 1)'(POS_MAX)) begin
                n_position = POS_W'(w_up_sum - (POS_W + 1)'(POS_MOD));
            end else begin
                n_position = w_up_sum[POS_W-1:0];
            end
        end else begin
            if (w_dn_diff[POS_W]) begin
                n_position = POS_W'(w_dn_diff + (POS_W + 1)'(POS_MOD));
            end else begin
                n_position = w_dn_diff[POS_W-1:0];
            end
        end
    end

    // Sample: shortest wrapped distance since the last sample, signed by direction.
    always_comb begin
        w_delta     = $signed({1'b0, r_position}) - $signed({1'b0, r_last_pos});
        w_delta_neg = -w_delta;
        w_dist_abs  = w_delta[POS_W] ? w_delta_neg[POS_W-1:0] : w_delta[POS_W-1:0];
        if (w_dist_abs > POS_W'(HALF_TURN)) begin
            w_dist = POS_W'(POS_MOD) - w_dist_abs;
        end else begin
            w_dist = w_dist_abs;
        end
        case (r_dir)
            DIR_FWD: w_entry = $signed(w_dist);
            DIR_REV: w_entry = -$signed(w_dist);
            default: w_entry = '0;
        endcase
        if (r_idx == IDX_W'(SAMPLE_DEPTH - 1)) begin
            n_idx_inc = '0;
        end else begin
            n_idx_inc = r_idx + IDX_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_position <= '0;
            r_level    <= '0;
            r_dir      <= DIR_STOP;
            r_last_pos <= '0;
            r_idx      <= '0;
        end else if (accept) begin
            if (is_drive) begin
                r_position <= n_position;
                r_level    <= n_level;
                r_dir      <= n_dir;
            end
            if (is_sample) begin
                r_last_pos <= r_position;
                r_idx      <= n_idx_inc;
            end
        end
    end

    // The ring is read at the new index on accept and written back from stage A.
    always_comb begin
        ring_req.rd_en   = accept && is_sample;
        ring_req.rd_addr = n_idx_inc;
        ring_req.wr_en   = a_go && r_a_sample;
        ring_req.wr_addr = r_a_idx;
        ring_req.wr_data = r_a_entry;
    end

    spm_ring u_ring (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (ring_req),
        .o_rd_data (ring_old)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (a_free) begin
            r_a_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_a_pos    <= is_drive ? n_position : r_position;
            r_a_sample <= is_sample;
            r_a_entry  <= w_entry;
            r_a_idx    <= n_idx_inc;
        end
    end

    // Stage A: running sum update, coarse position and home switch.
    always_comb begin
        n_sum    = r_sum + SUM_W'(r_a_entry) - SUM_W'(ring_old);
        w_cprod  = r_a_pos * COARSE_MUL_W'(COARSE_MUL);
        w_coarse = COARSE_W'(w_cprod >> COARSE_SH);
        w_home   = (r_a_pos < POS_W'(HOME_LOW)) || (r_a_pos > POS_W'(HOME_HIGH));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
        end else if (a_go && r_a_sample) begin
            r_sum <= n_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (b_free) begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_go) begin
            r_b_coarse <= w_coarse;
            r_b_home   <= w_home;
            r_b_sample <= r_a_sample;
            r_b_sum    <= n_sum;
        end
    end

    // Stage B: divide the magnitude by 3 * SAMPLE_DEPTH, then restore the sign so the result
    // truncates toward zero.
    always_comb begin
        w_mag_full = r_b_sum[SUM_W-1] ? SUM_W'(-r_b_sum) : SUM_W'(r_b_sum);
        w_mag      = w_mag_full[ABS_W-1:0];
        w_qprod    = w_mag * RECIP_W'(DIV_RECIP);
        w_quo      = SPD_W'(w_qprod >> DIV_SH);
        w_est      = r_b_sum[SUM_W-1] ? -$signed(w_quo) : $signed(w_quo);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (o_free) begin
            r_o_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_b_valid && o_free) begin
            r_o_coarse <= r_b_coarse;
            r_o_home   <= r_b_home;
            r_o_speed  <= r_b_sample ? w_est : '0;
        end
    end

    assign o_out.valid           = r_o_valid;
    assign o_out.coarse_position = r_o_coarse;
    assign o_out.home_switch     = r_o_home;
    assign o_out.speed_estimate  = r_o_speed;

    // The read for a new sample never hits the entry being written back.
    `SPM_ASSERT_NOW(a_ring_no_collide, ring_req.rd_en && ring_req.wr_en, ring_req.rd_addr != ring_req.wr_addr)
    // An accepted item always lands in stage A.
    `SPM_ASSERT_NEXT(a_accept_fills_a, accept, r_a_valid)
    // Position stays on the track and the speed level within its bounds.
    `SPM_ASSERT_NOW(a_state_range, 1'b1, (r_position <= POS_W'(POS_MAX)) && (r_level <= LVL_W'(SPEED_MAX)))

endmodule

### src/spm_ring.sv
// Sample ring memory with registered read and per-entry valid bits.
module spm_ring
    import spm_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_ring_req i_req,
    output t_entry    o_rd_data
);

    t_entry                  r_mem [SAMPLE_DEPTH];
    logic [SAMPLE_DEPTH-1:0] r_vld;
    t_entry                  r_rd_data;
    logic                    r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.rd_addr];
        end
    end

    // An entry never written since reset reads as zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_req.wr_en) begin
                r_vld[i_req.wr_addr] <= 1'b1;
            end
            if (i_req.rd_en) begin
                r_rd_vld <= r_vld[i_req.rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_vld ? r_rd_data : '0;

endmodule

### dv/spinning_mech_position_speed_model_unit_test.sv
// Self-checking testbench for the spinning mechanism position and speed model unit.
module spinning_mech_position_speed_model_unit_test;
    import spm_pkg::*;

    localparam int CLK_PERIOD    = 8;
    localparam int RESET_CYCLES  = 4;
    localparam int HOLD_CYCLES   = 300;
    localparam int DRAIN_CYCLES  = 20;
    localparam int TIMEOUT_TIME  = 500_000 * CLK_PERIOD;
    localparam int PHASE_ITEMS   = 290;
    localparam int COARSE_STEP   = 5;

    // Opcodes that the package does not name: a plain read and the unused code.
    localparam logic [1:0] OPC_READ   = 2'd2;
    localparam logic [1:0] OPC_UNUSED = 2'd3;

    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } t_idle_mode;

    typedef struct packed {
        logic [COARSE_W-1:0]     coarse_position;
        logic                    home_switch;
        logic signed [SPD_W-1:0] speed_estimate;
    } t_mech_result;

    // One directed item; when pinned is set the typed-in result is expected instead of the
    // predicted one.
    typedef struct packed {
        logic [1:0]              opcode;
        logic [1:0]              reg_offset;
        logic [7:0]              write_data;
        logic                    pinned;
        logic [COARSE_W-1:0]     coarse_position;
        logic                    home_switch;
        logic signed [SPD_W-1:0] speed_estimate;
    } t_directed_row;

    localparam int DIRECTED_ROWS = 23;

    t_directed_row directed_rows [DIRECTED_ROWS] = '{
        // Reads right after reset, the unused opcode and a sample before any drive write.
        '{OPC_READ,   2'd0,         8'h00, 1'b1, 10'd0, 1'b1, 11'sd0},
        '{OPC_UNUSED, 2'd3,         8'hFF, 1'b1, 10'd0, 1'b1, 11'sd0},
        '{OPC_SAMPLE, 2'd0,         8'h00, 1'b1, 10'd0, 1'b1, 11'sd0},
        // Writes to offsets that do not drive the mechanism.
        '{OPC_DRIVE,  2'd0,         8'hFF, 1'b1, 10'd0, 1'b1, 11'sd0},
        '{OPC_DRIVE,  2'd1,         8'h05, 1'b1, 10'd0, 1'b1, 11'sd0},
        '{OPC_DRIVE,  2'd2,         8'h04, 1'b1, 10'd0, 1'b1, 11'sd0},
        // Speed down at the floor, then up to the ceiling and once past it.
        '{OPC_DRIVE,  DRIVE_OFFSET, 8'h00, 1'b1, 10'd0, 1'b1, 11'sd0},
        '{OPC_DRIVE,  DRIVE_OFFSET, 8'h05, 1'b1, 10'd0, 1'b1, 11'sd0},
        '{OPC_DRIVE,  DRIVE_OFFSET, 8'h05, 1'b1, 10'd0, 1'b1, 11'sd0},
        '{OPC_DRIVE,  DRIVE_OFFSET, 8'h05, 1'b1, 10'd1, 1'b1, 11'sd0},
        '{OPC_DRIVE,  DRIVE_OFFSET, 8'h05, 1'b1, 10'd2, 1'b1, 11'sd0},
        '{OPC_DRIVE,  DRIVE_OFFSET, 8'h05, 1'b1, 10'd2, 1'b1, 11'sd0},
        '{OPC_SAMPLE, 2'd3,         8'hFF, 1'b0, 10'd0, 1'b0, 11'sd0},
        // Reverse at full speed through position zero.
        '{OPC_DRIVE,  DRIVE_OFFSET, 8'h01, 1'b0, 10'd0, 1'b0, 11'sd0},
        '{OPC_DRIVE,  DRIVE_OFFSET, 8'h01, 1'b0, 10'd0, 1'b0, 11'sd0},
        '{OPC_DRIVE,  DRIVE_OFFSET, 8'h01, 1'b0, 10'd0, 1'b0, 11'sd0},
        '{OPC_DRIVE,  DRIVE_OFFSET, 8'h01, 1'b0, 10'd0, 1'b0, 11'sd0},
        '{OPC_SAMPLE, 2'd1,         8'h55, 1'b0, 10'd0, 1'b0, 11'sd0},
        '{OPC_DRIVE,  DRIVE_OFFSET, 8'hFB, 1'b0, 10'd0, 1'b0, 11'sd0},
        '{OPC_DRIVE,  DRIVE_OFFSET, 8'hFE, 1'b0, 10'd0, 1'b0, 11'sd0},
        '{OPC_DRIVE,  DRIVE_OFFSET, 8'h00, 1'b0, 10'd0, 1'b0, 11'sd0},
        '{OPC_SAMPLE, 2'd2,         8'hAA, 1'b0, 10'd0, 1'b0, 11'sd0},
        '{OPC_READ,   2'd1,         8'h7F, 1'b0, 10'd0, 1'b0, 11'sd0}
    };

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    // Driven copies of the channel inputs; they hold known values from time zero.
    logic       item_valid      = 1'b0;
    logic [1:0] item_opcode     = '0;
    logic [1:0] item_reg_offset = '0;
    logic [7:0] item_write_data = '0;
    logic       result_ready    = 1'b0;

    spm_in_if  in_ch ();
    spm_out_if out_ch ();

    assign in_ch.valid      = item_valid;
    assign in_ch.opcode     = item_opcode;
    assign in_ch.reg_offset = item_reg_offset;
    assign in_ch.write_data = item_write_data;
    assign out_ch.ready     = result_ready;

    spinning_mech_position_speed_model_unit DUT (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    t_idle_mode idle_mode = IDLE_NONE;
    int         items_sent = 0;
    int         error_count = 0;

    // The receiver starts a long hold-off each time this counter moves.
    int hold_requests = 0;
    int hold_seen     = 0;
    int hold_left     = 0;
    int stall_pct     = 0;

    // Pinned result that goes with the item currently offered.
    logic         item_pinned = 1'b0;
    t_mech_result item_pinned_result = '0;

    t_mech_result mech_results_due [$];
    t_mech_result predicted;
    t_mech_result oldest;

    // Mechanism state as the predictor sees it, reset values included.
    int mech_position  = 0;
    int mech_level     = 0;
    int mech_direction = 0;
    int last_sample_at = 0;
    int speed_ring [SAMPLE_DEPTH] = '{default: 0};
    int ring_index     = 0;
    int ring_sum       = 0;

    // Applies one item to the mechanism state and returns the result it should produce.
    function automatic t_mech_result advance_mechanism(logic [1:0] opcode,
                                                       logic [1:0] reg_offset,
                                                       logic [7:0] write_data);
        t_mech_result res;
        int distance;
        int entry;
        int speed;
        speed = 0;
        if (opcode == OPC_DRIVE) begin
            if (reg_offset == DRIVE_OFFSET) begin
                mech_direction = write_data[DIR_BIT_POS] ? 1 : -1;
                if (write_data[UP_BIT_POS]) begin
                    if (mech_level < SPEED_MAX) mech_level++;
                end else if (mech_level > 0) begin
                    mech_level--;
                end
                mech_position += mech_direction * mech_level;
                if (mech_position < 0) mech_position += POS_MOD;
                if (mech_position > POS_MAX) mech_position -= POS_MOD;
            end
        end else if (opcode == OPC_SAMPLE) begin
            // Shortest way round the wheel, signed by the present direction.
            distance = mech_position - last_sample_at;
            if (distance < 0) distance = -distance;
            if (distance > HALF_TURN) distance = POS_MOD - distance;
            last_sample_at = mech_position;
            ring_index = (ring_index + 1) % SAMPLE_DEPTH;
            entry = mech_direction * distance;
            ring_sum += entry - speed_ring[ring_index];
            speed_ring[ring_index] = entry;
            // Signed int division truncates toward zero at both steps.
            speed = (ring_sum / SAMPLE_DEPTH) / SPEED_DIV;
        end
        res.coarse_position = COARSE_W'(mech_position / COARSE_STEP);
        res.home_switch     = (mech_position < HOME_LOW) || (mech_position > HOME_HIGH);
        res.speed_estimate  = SPD_W'(speed);
        return res;
    endfunction

    // Offers one item from the falling edge on and returns once it has been accepted.
    task automatic offer_item(input logic [1:0] opcode, input logic [1:0] reg_offset,
                              input logic [7:0] write_data, input logic pinned,
                              input t_mech_result pinned_result);
        int gap_pct;
        gap_pct = (idle_mode == IDLE_SENDER) ? 78 : (idle_mode == IDLE_BOTH) ? 19 : 0;
        @(negedge clk);
        while ($urandom_range(99) < gap_pct) begin
            item_valid = 1'b0;
            @(negedge clk);
        end
        item_valid         = 1'b1;
        item_opcode        = opcode;
        item_reg_offset    = reg_offset;
        item_write_data    = write_data;
        item_pinned        = pinned;
        item_pinned_result = pinned_result;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        items_sent++;
    endtask

    // A write to the drive register with biased speed and direction bits.
    task automatic offer_drive(input int up_pct, input int fwd_pct);
        logic [7:0] data;
        data = 8'($urandom());
        data[UP_BIT_POS]  = ($urandom_range(99) < up_pct);
        data[DIR_BIT_POS] = ($urandom_range(99) < fwd_pct);
        offer_item(OPC_DRIVE, DRIVE_OFFSET, data, 1'b0, '0);
    endtask

    task automatic offer_sample();
        offer_item(OPC_SAMPLE, 2'($urandom()), 8'($urandom()), 1'b0, '0);
    endtask

    // Mostly bursts of drive writes closed by a sample, with reads, stray writes and lone
    // samples mixed in. Bursts are trimmed to what is left of the phase quota.
    task automatic run_random_phase(input t_idle_mode mode, input int quota);
        int first_item;
        int pick;
        int burst;
        int fwd_pct;
        int room;
        idle_mode  = mode;
        first_item = items_sent;
        while (items_sent - first_item < quota) begin
            room = quota - (items_sent - first_item);
            pick = $urandom_range(99);
            if (pick < 40) begin
                burst   = $urandom_range(1, 12);
                if (burst > room) burst = room;
                fwd_pct = $urandom_range(0, 100);
                repeat (burst) offer_drive(65, fwd_pct);
                offer_sample();
            end else if (pick < 48) begin
                // Long run in one direction, so that the ring sees large distances.
                burst   = $urandom_range(40, 160);
                if (burst > room) burst = room;
                fwd_pct = $urandom_range(1) ? 97 : 3;
                repeat (burst) offer_drive(90, fwd_pct);
                offer_sample();
            end else if (pick < 70) begin
                offer_sample();
            end else if (pick < 85) begin
                offer_item($urandom_range(1) ? OPC_READ : OPC_UNUSED, 2'($urandom()),
                           8'($urandom()), 1'b0, '0);
            end else begin
                offer_item(OPC_DRIVE, 2'($urandom_range(2)), 8'($urandom()), 1'b0, '0);
            end
        end
    endtask

    // Receiver: random stalls by mode, plus a long hold-off whenever one is requested.
    always @(negedge clk) begin
        if (hold_seen != hold_requests) begin
            hold_seen = hold_requests;
            hold_left = HOLD_CYCLES;
        end
        stall_pct = (idle_mode == IDLE_RECEIVER) ? 78 : (idle_mode == IDLE_BOTH) ? 19 : 0;
        if (hold_left > 0) begin
            hold_left--;
            result_ready = 1'b0;
        end else begin
            result_ready = ($urandom_range(99) >= stall_pct);
        end
    end

    // Every accepted item queues its expected result; every accepted result is checked
    // against the oldest one waiting.
    always @(posedge clk) begin
        if (rst_n) begin
            if (in_ch.valid && in_ch.ready) begin
                predicted = advance_mechanism(in_ch.opcode, in_ch.reg_offset,
                                              in_ch.write_data);
                if (item_pinned) predicted = item_pinned_result;
                mech_results_due.push_back(predicted);
            end
            if (out_ch.valid && out_ch.ready) begin
                if (mech_results_due.size() == 0) begin
                    $error("result item arrived with no result expected");
                    error_count++;
                end else begin
                    oldest = mech_results_due.pop_front();
                    if (out_ch.coarse_position !== oldest.coarse_position) begin
                        $error("coarse_position: expected %0d, got %0d",
                               oldest.coarse_position, out_ch.coarse_position);
                        error_count++;
                    end
                    if (out_ch.home_switch !== oldest.home_switch) begin
                        $error("home_switch: expected %0d, got %0d",
                               oldest.home_switch, out_ch.home_switch);
                        error_count++;
                    end
                    if (out_ch.speed_estimate !== oldest.speed_estimate) begin
                        $error("speed_estimate: expected %0d, got %0d",
                               oldest.speed_estimate, out_ch.speed_estimate);
                        error_count++;
                    end
                end
            end
        end
    end

    initial begin
        t_mech_result pinned_result;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed items, back to back with the receiver always ready.
        for (int row = 0; row < DIRECTED_ROWS; row++) begin
            pinned_result.coarse_position = directed_rows[row].coarse_position;
            pinned_result.home_switch     = directed_rows[row].home_switch;
            pinned_result.speed_estimate  = directed_rows[row].speed_estimate;
            offer_item(directed_rows[row].opcode, directed_rows[row].reg_offset,
                       directed_rows[row].write_data, directed_rows[row].pinned,
                       pinned_result);
        end

        // The first random phase opens with a long receiver hold-off so the pipeline
        // fills and pushes back on the input.
        hold_requests++;
        run_random_phase(IDLE_NONE, PHASE_ITEMS);
        run_random_phase(IDLE_SENDER, PHASE_ITEMS);
        run_random_phase(IDLE_RECEIVER, PHASE_ITEMS);

        // Let the block drain completely before going on.
        @(negedge clk);
        item_valid = 1'b0;
        while (mech_results_due.size() != 0) @(posedge clk);

        run_random_phase(IDLE_BOTH, PHASE_ITEMS);
        run_random_phase(IDLE_NONE, PHASE_ITEMS);
        run_random_phase(IDLE_BOTH, PHASE_ITEMS);

        @(negedge clk);
        item_valid = 1'b0;
        while (mech_results_due.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #(TIMEOUT_TIME);
        $display("== FAIL ==");
        $finish;
    end

endmodule
